[design/pwsc_pkg.sv]
`default_nettype none
package pwsc_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int DIV_STEPS = 34;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] CFG_ALPHA          = 3'd0;
    localparam logic [2:0] CFG_COLOUR_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_GRADIENT_LIMIT = 3'd2;
    localparam logic [2:0] CFG_WEIGHT_GAMMA   = 3'd3;
    localparam logic [2:0] CFG_DISPARITY_MIN  = 3'd4;
    localparam logic [2:0] CFG_DISPARITY_MAX  = 3'd5;
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd6;
    localparam logic [2:0] CFG_PUNISH_COST    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_BLEND,
        ST_DIV,
        ST_EXP1,
        ST_EXP2,
        ST_MUL,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic blend;
        logic div_step;
        logic exp1;
        logic exp2;
        logic mul;
        logic acc;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic last;
        logic out_free;
    } t_status;

    // 2^-(i/16) in Q.16
    function automatic logic [16:0] pow2_neg(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            5'd16: v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/patch_weighted_stereo_cost.sv]
`default_nettype none
// Adaptive-weight patch matching cost. One beat is one patch pixel; the block
// sums the weighted cost of each pixel and presents the saturated 48-bit Q.16
// total on the beat marked last_in_patch, then clears the sum. Each pixel
// passes, one at a time, through capture, setup (matched column, colour
// and gradient differences, then blend), the bit-serial divider that forms
// colour distance over gamma, exp evaluation, a weight multiply and an
// accumulate. The result sits in an output register, so the next patch
// pixel is taken while a finished cost waits; only a second finished cost
// stalls. The configuration port is a plain write (index, data), to be
// used while idle.
module patch_weighted_stereo_cost (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [23:0]        i_centre_colour,
    input  wire logic [23:0]        i_neighbour_colour,
    input  wire logic [23:0]        i_right_colour_low,
    input  wire logic [23:0]        i_right_colour_high,
    input  wire logic signed [11:0] i_left_grad_x,
    input  wire logic signed [11:0] i_left_grad_y,
    input  wire logic signed [11:0] i_right_grad_x,
    input  wire logic signed [11:0] i_right_grad_y,
    input  wire logic [11:0]        i_column,
    input  wire logic signed [16:0] i_disparity,
    input  wire logic               i_in_image,
    input  wire logic               i_last_in_patch,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [47:0]             o_patch_cost
);
    import pwsc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: one pixel at a time through the datapath steps
    pwsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: config registers, cost terms, divider, exp, accumulator
    pwsc_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_centre_colour     (i_centre_colour),
        .i_neighbour_colour  (i_neighbour_colour),
        .i_right_colour_low  (i_right_colour_low),
        .i_right_colour_high (i_right_colour_high),
        .i_left_grad_x       (i_left_grad_x),
        .i_left_grad_y       (i_left_grad_y),
        .i_right_grad_x      (i_right_grad_x),
        .i_right_grad_y      (i_right_grad_y),
        .i_column            (i_column),
        .i_disparity         (i_disparity),
        .i_in_image          (i_in_image),
        .i_last_in_patch     (i_last_in_patch),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_patch_cost        (o_patch_cost)
    );

endmodule
`default_nettype wire

[design/pwsc_ctrl.sv]
`default_nettype none
module pwsc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire pwsc_pkg::t_status i_status,
    output pwsc_pkg::t_cmd         o_cmd
);
    import pwsc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_PREP;
            ST_PREP:  n_state = ST_BLEND;
            ST_BLEND: n_state = ST_DIV;
            ST_DIV:   if (i_status.div_last) n_state = ST_EXP1;
            ST_EXP1:  n_state = ST_EXP2;
            ST_EXP2:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   if (!i_status.last || i_status.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            ST_PREP:  o_cmd.prep = 1'b1;
            ST_BLEND: o_cmd.blend = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_EXP1:  o_cmd.exp1 = 1'b1;
            ST_EXP2:  o_cmd.exp2 = 1'b1;
            ST_MUL:   o_cmd.mul = 1'b1;
            ST_ACC:   o_cmd.acc = !i_status.last || i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[design/pwsc_dpath.sv]
`default_nettype none
module pwsc_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pwsc_pkg::t_cmd    i_cmd,
    output pwsc_pkg::t_status      o_status,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [23:0]       i_cfg_data,
    input  wire logic [23:0]       i_centre_colour,
    input  wire logic [23:0]       i_neighbour_colour,
    input  wire logic [23:0]       i_right_colour_low,
    input  wire logic [23:0]       i_right_colour_high,
    input  wire logic signed [11:0] i_left_grad_x,
    input  wire logic signed [11:0] i_left_grad_y,
    input  wire logic signed [11:0] i_right_grad_x,
    input  wire logic signed [11:0] i_right_grad_y,
    input  wire logic [11:0]       i_column,
    input  wire logic signed [16:0] i_disparity,
    input  wire logic              i_in_image,
    input  wire logic              i_last_in_patch,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [47:0]            o_patch_cost
);
    import pwsc_pkg::*;

    // config
    logic [16:0]        r_alpha;
    logic [17:0]        r_colour_limit, r_gradient_limit;
    logic [15:0]        r_gamma;
    logic signed [16:0] r_dmin, r_dmax;
    logic [12:0]        r_width_cfg;
    logic [23:0]        r_punish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha          <= 17'd58982;
            r_colour_limit   <= 18'd2560;
            r_gradient_limit <= 18'd512;
            r_gamma          <= 16'd2560;
            r_dmin           <= 17'sd0;
            r_dmax           <= 17'sd16384;
            r_width_cfg      <= 13'd640;
            r_punish         <= 24'd30720;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA:          r_alpha <= i_cfg_data[16:0];
                CFG_COLOUR_LIMIT:   r_colour_limit <= i_cfg_data[17:0];
                CFG_GRADIENT_LIMIT: r_gradient_limit <= i_cfg_data[17:0];
                CFG_WEIGHT_GAMMA:   r_gamma <= i_cfg_data[15:0];
                CFG_DISPARITY_MIN:  r_dmin <= $signed(i_cfg_data[16:0]);
                CFG_DISPARITY_MAX:  r_dmax <= $signed(i_cfg_data[16:0]);
                CFG_IMAGE_WIDTH:    r_width_cfg <= i_cfg_data[12:0];
                CFG_PUNISH_COST:    r_punish <= i_cfg_data;
                default:            r_alpha <= r_alpha;
            endcase
        end
    end

    logic [16:0] alpha_c;
    logic [12:0] width_c;
    logic [15:0] gamma_c;
    assign alpha_c = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
    assign width_c = (r_width_cfg > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_width_cfg;
    assign gamma_c = (r_gamma == 16'd0) ? 16'd1 : r_gamma;

    // captured item
    logic [23:0]        r_cc, r_nb, r_rlo, r_rhi;
    logic signed [11:0] r_lgx, r_lgy, r_rgx, r_rgy;
    logic [11:0]        r_col;
    logic signed [16:0] r_d;
    logic               r_inside, r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cc     <= i_centre_colour;
            r_nb     <= i_neighbour_colour;
            r_rlo    <= i_right_colour_low;
            r_rhi    <= i_right_colour_high;
            r_lgx    <= i_left_grad_x;
            r_lgy    <= i_left_grad_y;
            r_rgx    <= i_right_grad_x;
            r_rgy    <= i_right_grad_y;
            r_col    <= i_column;
            r_d      <= i_disparity;
            r_inside <= i_in_image;
            r_last   <= i_last_in_patch;
        end
    end

    // prep: matched column, colour and gradient differences
    logic signed [22:0] xr;
    logic               outside;
    logic [12:0]        x1;
    logic [7:0]         frac;
    logic [23:0]        hi_px;
    logic [9:0]         dc_int;
    logic [17:0]        dc_sum, dc_c;
    logic [12:0]        dg_sum;
    logic [20:0]        dg_sh;
    logic [17:0]        dg_c;
    logic [11:0]        agx, agy;

    assign xr      = $signed({3'b000, r_col, 8'h00}) - 23'(r_d);
    assign outside = xr[22] || (xr[21:0] >= {1'b0, width_c, 8'h00});
    assign x1      = xr[20:8];
    assign frac    = xr[7:0];
    assign hi_px   = ({1'b0, x1} + 14'd1 < {1'b0, width_c}) ? r_rhi : r_rlo;

    always_comb begin
        logic [7:0]  a, b, lo, hi;
        logic [15:0] q, l;
        dc_int = '0;
        dc_sum = '0;
        for (int k = 0; k < 3; k++) begin
            a  = r_cc[8*k +: 8];
            b  = r_nb[8*k +: 8];
            lo = r_rlo[8*k +: 8];
            hi = hi_px[8*k +: 8];
            dc_int = dc_int + 10'((a >= b) ? a - b : b - a);
            q = 16'((9'd256 - {1'b0, frac}) * lo) + 16'(frac * hi);
            l = {b, 8'h00};
            dc_sum = dc_sum + 18'((l >= q) ? l - q : q - l);
        end
    end

    assign dc_c   = (dc_sum > r_colour_limit) ? r_colour_limit : dc_sum;
    assign agx    = (r_lgx >= r_rgx) ? 12'(r_lgx - r_rgx) : 12'(r_rgx - r_lgx);
    assign agy    = (r_lgy >= r_rgy) ? 12'(r_lgy - r_rgy) : 12'(r_rgy - r_lgy);
    assign dg_sum = {1'b0, agx} + {1'b0, agy};
    assign dg_sh  = {dg_sum, 8'h00};
    assign dg_c   = (dg_sh > {3'b000, r_gradient_limit}) ? r_gradient_limit : dg_sh[17:0];

    logic [9:0]  r_dcint;
    logic [17:0] r_dc, r_dg;
    logic        r_punish_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_dcint      <= dc_int;
            r_dc         <= outside ? r_colour_limit : dc_c;
            r_dg         <= outside ? r_gradient_limit : dg_c;
            r_punish_sel <= (r_d < r_dmin) || (r_d > r_dmax);
        end
    end

    // blend
    logic [34:0] r_blend;
    logic [16:0] alpha_inv;
    assign alpha_inv = 17'd65536 - alpha_c;

    always_ff @(posedge i_clk) begin
        if (i_cmd.blend) begin
            r_blend <= 35'(alpha_inv * r_dc) + 35'(alpha_c * r_dg);
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [33:0] r_div_nq;
    logic [15:0] r_rem;
    logic [5:0]  r_div_cnt;
    logic [16:0] rem_sh;
    logic        q_bit;

    assign rem_sh = {r_rem, r_div_nq[33]};
    assign q_bit  = rem_sh >= {1'b0, gamma_c};

    always_ff @(posedge i_clk) begin
        if (i_cmd.blend) begin
            r_div_nq  <= {r_dcint, 24'h000000};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_nq  <= {r_div_nq[32:0], q_bit};
            r_rem     <= q_bit ? 16'(rem_sh - {1'b0, gamma_c}) : rem_sh[15:0];
            r_div_cnt <= r_div_cnt + 6'd1;
        end
    end

    // exp2 weight; beyond 2^20 the exponent exceeds the table reach
    logic [36:0] y_prod;
    logic [20:0] y;
    logic [20:0] r_y;
    logic        r_wzero;

    assign y_prod = 37'(r_div_nq[19:0] * LOG2E_Q16) + 37'd32768;
    assign y      = y_prod[36:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp1) begin
            r_y     <= y;
            r_wzero <= (|r_div_nq[33:20]) || (y[20:16] >= 5'd17);
        end
    end

    logic [16:0] tab_lo, tab_hi, m;
    logic [11:0] tab_diff;
    logic [23:0] interp;
    logic [16:0] r_w;

    assign tab_lo   = pow2_neg({1'b0, r_y[15:12]});
    assign tab_hi   = pow2_neg(5'({1'b0, r_y[15:12]} + 5'd1));
    assign tab_diff = 12'(tab_lo - tab_hi);
    assign interp   = 24'(tab_diff * r_y[11:0]) + 24'd2048;
    assign m        = tab_lo - 17'(interp[23:12]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp2) begin
            r_w <= r_wzero ? 17'd0 : (m >> r_y[20:16]);
        end
    end

    // weighted contribution
    logic [51:0] c_prod;
    logic [27:0] r_contrib;
    assign c_prod = r_blend * r_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_contrib <= c_prod[51:24];
        end
    end

    // accumulator and output register
    logic [47:0] r_sum;
    logic        r_out_valid;
    logic [47:0] r_out_cost;
    logic [31:0] add_val;
    logic [48:0] sum_w;
    logic [47:0] sum_sat;
    logic        out_free;

    assign out_free = !r_out_valid || i_ready;
    assign add_val  = !r_inside ? 32'd0 :
                      r_punish_sel ? {r_punish, 8'h00} : {4'h0, r_contrib};
    assign sum_w    = {1'b0, r_sum} + 49'(add_val);
    assign sum_sat  = sum_w[48] ? SUM_MAX : sum_w[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            if (i_cmd.acc) begin
                if (r_last) begin
                    r_sum       <= '0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_sum <= sum_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && r_last) r_out_cost <= sum_sat;
    end

    assign o_valid           = r_out_valid;
    assign o_patch_cost      = r_out_cost;
    assign o_status.div_last = (r_div_cnt == 6'(DIV_STEPS - 1));
    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;

`ifndef SYNTHESIS
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc && r_last) |=> (r_sum == '0))
        else $error("patch sum not cleared after last beat");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(i_cmd.acc && r_last)) |=> !r_out_valid)
        else $error("result raised without last beat");
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exp2 |=> (r_w <= 17'd65536))
        else $error("support weight above one");
`endif

endmodule
`default_nettype wire
